// ----- hdl/multi_joint_position_ramp_defines.svh -----
// Assertion macros used by the multi-joint position ramp checker.
`ifndef MULTI_JOINT_POSITION_RAMP_DEFINES_SVH
`define MULTI_JOINT_POSITION_RAMP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MJPR_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MJPR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mjpr_pkg.sv -----
// Package: types and constants of the multi-joint position ramp.
`timescale 1ns / 1ps
`default_nettype none

package mjpr_pkg;

   localparam int MJPR_MAX_JOINTS     = 16;
   localparam int MJPR_POSITION_BITS  = 24;
   localparam int JOINT_INDEX_W       = 4;
   localparam int JOINT_COUNT_W       = 5;
   localparam int STEP_SIZE_W         = 20;
   localparam int CSR_DATA_W          = 20;
   localparam int CSR_INDEX_W         = 1;

   localparam logic [JOINT_COUNT_W-1:0] JOINT_COUNT_RESET = 5'd7;
   localparam logic [STEP_SIZE_W-1:0]   STEP_SIZE_RESET   = 20'd5243;
   localparam logic [JOINT_COUNT_W-1:0] ELEMENT_COUNT_MAX = 5'd31;

   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_COMMAND = 2'd1,
      OP_TICK    = 2'd2,
      OP_LIMITS  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_JOINT_COUNT = 1'b0,
      CSR_STEP_SIZE   = 1'b1
   } csr_reg_type;

   // Control of the request held in the input register.
   typedef struct packed {
      logic       fire;
      opcode_type op;
      logic       last;
   } req_ctl_type;

   // Status flags of one response.
   typedef struct packed {
      logic joint_reached;
      logic all_reached;
      logic moving;
      logic length_error;
   } rsp_flags_type;

endpackage

`default_nettype wire

// ----- hdl/mjpr_joint_step.sv -----
// One joint step: offset by the step size, then clamp to limits or snap to target.
`timescale 1ns / 1ps
`default_nettype none

module mjpr_joint_step import mjpr_pkg::*; #(
   parameter int POSITION_BITS = MJPR_POSITION_BITS
) (
   input  wire logic signed [POSITION_BITS-1:0] measured,
   input  wire logic        [STEP_SIZE_W-1:0]   step_size,
   input  wire logic                            down,
   input  wire logic signed [POSITION_BITS-1:0] lower,
   input  wire logic signed [POSITION_BITS-1:0] upper,
   input  wire logic signed [POSITION_BITS-1:0] target,
   output logic      signed [POSITION_BITS-1:0] next_setpoint,
   output logic                                 done
);

   localparam int BaseW = (POSITION_BITS > STEP_SIZE_W) ? POSITION_BITS : STEP_SIZE_W + 1;
   localparam int SumW  = BaseW + 1;
   localparam int ExtW  = SumW - POSITION_BITS;

   logic signed [SumW-1:0] meas_x;
   logic signed [SumW-1:0] step_x;
   logic signed [SumW-1:0] lower_x;
   logic signed [SumW-1:0] upper_x;
   logic signed [SumW-1:0] target_x;
   logic signed [SumW-1:0] sum;

   assign meas_x   = {{ExtW{measured[POSITION_BITS-1]}}, measured};
   assign lower_x  = {{ExtW{lower[POSITION_BITS-1]}}, lower};
   assign upper_x  = {{ExtW{upper[POSITION_BITS-1]}}, upper};
   assign target_x = {{ExtW{target[POSITION_BITS-1]}}, target};
   assign step_x   = {{(SumW-STEP_SIZE_W){1'b0}}, step_size};
   assign sum      = down ? (meas_x - step_x) : (meas_x + step_x);

   // Lower limit wins, then upper limit, then the target.
   always_comb begin
      done          = 1'b1;
      next_setpoint = sum[POSITION_BITS-1:0];
      priority if (sum <= lower_x) begin
         next_setpoint = lower;
      end else if (sum >= upper_x) begin
         next_setpoint = upper;
      end else if ((!down && sum >= target_x) || (down && sum <= target_x)) begin
         next_setpoint = target;
      end else begin
         done = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/mjpr_state.sv -----
// Per-joint stores, motion control and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module mjpr_state import mjpr_pkg::*; #(
   parameter int MAX_JOINTS    = MJPR_MAX_JOINTS,
   parameter int POSITION_BITS = MJPR_POSITION_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic        [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic        [CSR_DATA_W-1:0]    csr_wdata,
   input  wire req_ctl_type                     ctl,
   input  wire logic        [JOINT_INDEX_W-1:0] joint_index,
   input  wire logic signed [POSITION_BITS-1:0] measured,
   input  wire logic signed [POSITION_BITS-1:0] target_or_lower,
   input  wire logic signed [POSITION_BITS-1:0] upper_limit,
   output logic      signed [POSITION_BITS-1:0] setpoint_out,
   output rsp_flags_type                        flags_out
);

   localparam int IdxW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   logic signed [POSITION_BITS-1:0] setpoint_ff [MAX_JOINTS];
   logic signed [POSITION_BITS-1:0] target_ff   [MAX_JOINTS];
   logic signed [POSITION_BITS-1:0] lower_ff    [MAX_JOINTS];
   logic signed [POSITION_BITS-1:0] upper_ff    [MAX_JOINTS];
   logic [MAX_JOINTS-1:0]    dir_ff;
   logic [MAX_JOINTS-1:0]    reached_ff, reached_in;
   logic                     active_ff, active_in;
   logic [JOINT_COUNT_W-1:0] elem_cnt_ff, elem_cnt_in;
   logic [JOINT_COUNT_W-1:0] joint_count_ff;
   logic [STEP_SIZE_W-1:0]   step_size_ff;

   logic [7:0]            idx_wide;
   logic [IdxW-1:0]       idx;
   logic                  idx_ok;
   logic [7:0]            used;
   logic [MAX_JOINTS-1:0] used_mask;
   logic [MAX_JOINTS-1:0] idx_onehot;
   logic                  in_use;
   logic [JOINT_COUNT_W-1:0] elem_inc;

   logic signed [POSITION_BITS-1:0] cur_setpoint;
   logic signed [POSITION_BITS-1:0] step_setpoint;
   logic                            step_done;
   logic                            sp_wr;
   logic signed [POSITION_BITS-1:0] sp_wr_val;
   logic                            tgt_wr;
   logic                            lim_wr;
   logic                            len_err;
   logic                            all_pulse;

   assign idx_wide   = 8'(joint_index);
   assign idx        = idx_wide[IdxW-1:0];
   assign idx_ok     = idx_wide < 8'(MAX_JOINTS);
   assign idx_onehot = MAX_JOINTS'(1) << idx;
   assign in_use     = idx_wide < used;
   assign cur_setpoint = setpoint_ff[idx];
   assign elem_inc   = (elem_cnt_ff < ELEMENT_COUNT_MAX) ?
                       elem_cnt_ff + JOINT_COUNT_W'(1) : elem_cnt_ff;

   // Joint count of zero acts as one; above the store depth it acts as the depth.
   always_comb begin
      priority if (joint_count_ff == '0) begin
         used = 8'd1;
      end else if (8'(joint_count_ff) > 8'(MAX_JOINTS)) begin
         used = 8'(MAX_JOINTS);
      end else begin
         used = 8'(joint_count_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_JOINTS; i++) begin
         used_mask[i] = 8'(i) < used;
      end
   end

   mjpr_joint_step #(
      .POSITION_BITS (POSITION_BITS)
   ) u_step (
      .measured      (measured),
      .step_size     (step_size_ff),
      .down          (dir_ff[idx]),
      .lower         (lower_ff[idx]),
      .upper         (upper_ff[idx]),
      .target        (target_ff[idx]),
      .next_setpoint (step_setpoint),
      .done          (step_done)
   );

   always_comb begin
      sp_wr       = 1'b0;
      sp_wr_val   = measured;
      tgt_wr      = 1'b0;
      lim_wr      = 1'b0;
      len_err     = 1'b0;
      all_pulse   = 1'b0;
      reached_in  = reached_ff;
      active_in   = active_ff;
      elem_cnt_in = elem_cnt_ff;
      unique case (ctl.op)
         OP_HOLD: begin
            sp_wr     = idx_ok;
            sp_wr_val = measured;
         end
         OP_COMMAND: begin
            tgt_wr      = idx_ok;
            elem_cnt_in = elem_inc;
            if (ctl.last) begin
               if (8'(elem_inc) != used) begin
                  len_err   = 1'b1;
                  active_in = 1'b0;
               end else begin
                  reached_in = '0;
                  active_in  = 1'b1;
               end
               elem_cnt_in = '0;
            end
         end
         OP_TICK: begin
            if (active_ff && idx_ok && in_use && !reached_ff[idx]) begin
               sp_wr     = 1'b1;
               sp_wr_val = step_setpoint;
               if (step_done) begin
                  reached_in = reached_ff | idx_onehot;
               end
            end
            if (ctl.last && active_ff && ((reached_in & used_mask) == used_mask)) begin
               active_in = 1'b0;
               all_pulse = 1'b1;
            end
         end
         OP_LIMITS: begin
            lim_wr = idx_ok;
         end
      endcase
   end

   assign setpoint_out            = idx_ok ? (sp_wr ? sp_wr_val : cur_setpoint) : '0;
   assign flags_out.joint_reached = idx_ok & reached_in[idx];
   assign flags_out.all_reached   = all_pulse;
   assign flags_out.moving        = active_in;
   assign flags_out.length_error  = len_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_JOINTS; i++) begin
            setpoint_ff[i] <= '0;
         end
         reached_ff     <= '0;
         active_ff      <= 1'b0;
         elem_cnt_ff    <= '0;
         joint_count_ff <= JOINT_COUNT_RESET;
         step_size_ff   <= STEP_SIZE_RESET;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_reg_type'(csr_index))
               CSR_JOINT_COUNT: joint_count_ff <= csr_wdata[JOINT_COUNT_W-1:0];
               CSR_STEP_SIZE:   step_size_ff   <= csr_wdata[STEP_SIZE_W-1:0];
            endcase
         end
         if (ctl.fire) begin
            if (sp_wr) begin
               setpoint_ff[idx] <= sp_wr_val;
            end
            reached_ff  <= reached_in;
            active_ff   <= active_in;
            elem_cnt_ff <= elem_cnt_in;
         end
      end
   end

   // Target, direction and limit stores hold garbage until written.
   always_ff @(posedge clock) begin
      if (ctl.fire && tgt_wr) begin
         target_ff[idx] <= target_or_lower;
         dir_ff[idx]    <= measured > target_or_lower;
      end
      if (ctl.fire && lim_wr) begin
         lower_ff[idx] <= target_or_lower;
         upper_ff[idx] <= upper_limit;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/multi_joint_position_ramp.sv -----
// Top level of the multi-joint position ramp: input register, joint state, result register.
`timescale 1ns / 1ps
`default_nettype none

// Multi-joint setpoint ramp. Each request carries one opcode for one joint:
// hold (setpoint follows the measured position), command element (store
// target and direction; the last element checks the element count against
// joint_count and starts motion or flags length_error), tick element (step
// the setpoint by step_size from the measured position, clamp to the limits
// or snap to the target and mark the joint done), and load limits. Every
// request yields exactly one response. Throughput is one request per clock
// while rsp_ready keeps the result register draining; a request passes the
// input register and then the result register, with the per-joint register
// files read, updated and written between them. A response waiting on
// rsp_ready does not block the next request from entering an empty input
// register. Configuration writes (index 0 joint_count, index 1 step_size)
// take effect at once and must only be issued while no request is in flight.
// The setpoint store clears on the synchronous reset; limits and targets
// must be loaded before a tick reads them.
module multi_joint_position_ramp import mjpr_pkg::*; #(
   parameter int MAX_JOINTS    = MJPR_MAX_JOINTS,
   parameter int POSITION_BITS = MJPR_POSITION_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic        [1:0]               req_opcode,
   input  wire logic        [JOINT_INDEX_W-1:0] req_joint_index,
   input  wire logic signed [POSITION_BITS-1:0] req_measured_position,
   input  wire logic signed [POSITION_BITS-1:0] req_target_or_lower,
   input  wire logic signed [POSITION_BITS-1:0] req_upper_limit,
   input  wire logic                            req_last_element,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic             [JOINT_INDEX_W-1:0] rsp_out_joint,
   output logic      signed [POSITION_BITS-1:0] rsp_setpoint,
   output logic                                 rsp_joint_reached,
   output logic                                 rsp_all_reached,
   output logic                                 rsp_moving,
   output logic                                 rsp_length_error,
   input  wire logic                            csr_wr_en,
   input  wire logic        [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic        [CSR_DATA_W-1:0]    csr_wdata
);

   // Input register.
   logic                            s1_valid_ff, s1_valid_in;
   opcode_type                      s1_op_ff;
   logic [JOINT_INDEX_W-1:0]        s1_joint_ff;
   logic signed [POSITION_BITS-1:0] s1_meas_ff;
   logic signed [POSITION_BITS-1:0] s1_tol_ff;
   logic signed [POSITION_BITS-1:0] s1_upper_ff;
   logic                            s1_last_ff;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [JOINT_INDEX_W-1:0]        rsp_joint_ff;
   logic signed [POSITION_BITS-1:0] rsp_setpoint_ff;
   rsp_flags_type                   rsp_flags_ff;

   logic                            advance;
   logic                            req_take;
   req_ctl_type                     ctl;
   logic signed [POSITION_BITS-1:0] next_setpoint;
   rsp_flags_type                   next_flags;

   // Advance the held request whenever the result register is empty or draining.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign ctl.fire = advance;
   assign ctl.op   = s1_op_ff;
   assign ctl.last = s1_last_ff;

   mjpr_state #(
      .MAX_JOINTS    (MAX_JOINTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_state (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .ctl             (ctl),
      .joint_index     (s1_joint_ff),
      .measured        (s1_meas_ff),
      .target_or_lower (s1_tol_ff),
      .upper_limit     (s1_upper_ff),
      .setpoint_out    (next_setpoint),
      .flags_out       (next_flags)
   );

   // Control: valid flags of both registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: capture on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= opcode_type'(req_opcode);
         s1_joint_ff <= req_joint_index;
         s1_meas_ff  <= req_measured_position;
         s1_tol_ff   <= req_target_or_lower;
         s1_upper_ff <= req_upper_limit;
         s1_last_ff  <= req_last_element;
      end
      if (advance) begin
         rsp_joint_ff    <= s1_joint_ff;
         rsp_setpoint_ff <= next_setpoint;
         rsp_flags_ff    <= next_flags;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_joint     = rsp_joint_ff;
   assign rsp_setpoint      = rsp_setpoint_ff;
   assign rsp_joint_reached = rsp_flags_ff.joint_reached;
   assign rsp_all_reached   = rsp_flags_ff.all_reached;
   assign rsp_moving        = rsp_flags_ff.moving;
   assign rsp_length_error  = rsp_flags_ff.length_error;

endmodule

`default_nettype wire

// ----- hdl/mjpr_checker.sv -----
// Port-level checks of the multi-joint position ramp, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_joint_position_ramp_defines.svh"

module mjpr_checker import mjpr_pkg::*; #(
   parameter int POSITION_BITS = MJPR_POSITION_BITS
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic        [JOINT_INDEX_W-1:0] rsp_out_joint,
   input wire logic signed [POSITION_BITS-1:0] rsp_setpoint,
   input wire logic                            rsp_all_reached,
   input wire logic                            rsp_moving,
   input wire logic                            rsp_length_error
);

   `MJPR_ASSERT_IMPL(a_error_stops_motion, clock, reset, rsp_valid && rsp_length_error, !rsp_moving && !rsp_all_reached, "length error left motion active")
   `MJPR_ASSERT_IMPL(a_done_stops_motion, clock, reset, rsp_valid && rsp_all_reached, !rsp_moving, "all_reached with motion still active")
   `MJPR_ASSERT_NEXT(a_stalled_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_setpoint) && $stable(rsp_out_joint), "stalled response changed")

endmodule

bind multi_joint_position_ramp mjpr_checker #(
   .POSITION_BITS (POSITION_BITS)
) u_mjpr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_joint    (rsp_out_joint),
   .rsp_setpoint     (rsp_setpoint),
   .rsp_all_reached  (rsp_all_reached),
   .rsp_moving       (rsp_moving),
   .rsp_length_error (rsp_length_error)
);

`default_nettype wire

// ----- tb/tb_multi_joint_position_ramp.sv -----
// Self-checking testbench for the multi-joint position ramp: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_multi_joint_position_ramp;
   import mjpr_pkg::*;

   localparam int     POS_W        = MJPR_POSITION_BITS;
   localparam longint POS_MAX      = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint POS_MIN      = -POS_MAX - 1;
   localparam int     RANDOM_ITEMS = 1700;
   // Two register stages inside the block; give it a little extra before touching CSRs.
   localparam int     SETTLE_CYCLES = 4;

   typedef logic signed [POS_W-1:0] position_type;

   // One setpoint report as it leaves the block.
   typedef struct packed {
      logic [JOINT_INDEX_W-1:0] joint;
      logic [POS_W-1:0]         setpoint;
      logic                     reached;
      logic                     all_done;
      logic                     moving;
      logic                     len_err;
   } joint_report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_opcode = '0;
   logic [JOINT_INDEX_W-1:0] req_joint_index = '0;
   position_type             req_measured_position = '0;
   position_type             req_target_or_lower = '0;
   position_type             req_upper_limit = '0;
   logic                     req_last_element = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [JOINT_INDEX_W-1:0] rsp_out_joint;
   position_type             rsp_setpoint;
   logic                     rsp_joint_reached;
   logic                     rsp_all_reached;
   logic                     rsp_moving;
   logic                     rsp_length_error;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   multi_joint_position_ramp u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_joint_index       (req_joint_index),
      .req_measured_position (req_measured_position),
      .req_target_or_lower   (req_target_or_lower),
      .req_upper_limit       (req_upper_limit),
      .req_last_element      (req_last_element),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_joint         (rsp_out_joint),
      .rsp_setpoint          (rsp_setpoint),
      .rsp_joint_reached     (rsp_joint_reached),
      .rsp_all_reached       (rsp_all_reached),
      .rsp_moving            (rsp_moving),
      .rsp_length_error      (rsp_length_error),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Mirror of the joint state, advanced once per request in send order.
   // ---------------------------------------------------------------------
   position_type              sp_mirror   [MJPR_MAX_JOINTS] = '{default: '0};
   position_type              tgt_mirror  [MJPR_MAX_JOINTS] = '{default: '0};
   logic                      down_mirror [MJPR_MAX_JOINTS] = '{default: 1'b0};
   position_type              lo_mirror   [MJPR_MAX_JOINTS] = '{default: '0};
   position_type              hi_mirror   [MJPR_MAX_JOINTS] = '{default: '0};
   logic [MJPR_MAX_JOINTS-1:0] done_mask  = '0;
   logic                      motion_on   = 1'b0;
   logic [JOINT_COUNT_W-1:0]  elem_count  = '0;
   logic [JOINT_COUNT_W-1:0]  jc_reg      = JOINT_COUNT_RESET;
   logic [STEP_SIZE_W-1:0]    step_reg    = STEP_SIZE_RESET;

   // Reports still owed by the block, oldest first.
   joint_report_type joint_reports_due [$];

   // Idle-pattern knobs for the sender and the receiver.
   int req_gap_max     = 4;
   int rsp_stall_max   = 4;
   int rsp_hold_cycles = 0;

   int items_sent         = 0;
   int reports_checked    = 0;
   int mismatch_count     = 0;
   int csr_writes         = 0;
   int length_errors_seen = 0;
   int completions_seen   = 0;

   function automatic position_type clip_pos(longint v);
      if (v > POS_MAX) return position_type'(POS_MAX);
      if (v < POS_MIN) return position_type'(POS_MIN);
      return position_type'(v);
   endfunction

   // Zero acts as one joint, anything above the table size as the full table.
   function automatic int used_joints();
      if (jc_reg == 0) return 1;
      if (jc_reg > MJPR_MAX_JOINTS) return MJPR_MAX_JOINTS;
      return int'(jc_reg);
   endfunction

   // Mostly moderate positions, now and then anything in the full Q3.20 range.
   function automatic position_type random_position();
      if ($urandom_range(0, 3) == 0) return position_type'($urandom);
      return clip_pos(longint'($urandom_range(0, 1 << 22)) - (longint'(1) << 21));
   endfunction

   // Apply one request to the mirror and return the report it should produce.
   function automatic joint_report_type predict_joint_update(opcode_type op,
         logic [JOINT_INDEX_W-1:0] j, position_type meas, position_type tol,
         position_type upp, logic last);
      joint_report_type           r;
      int                         n;
      logic [MJPR_MAX_JOINTS-1:0] use_mask;
      longint                     nv;
      logic                       done;
      n        = used_joints();
      use_mask = (n >= MJPR_MAX_JOINTS) ? '1 : MJPR_MAX_JOINTS'((32'd1 << n) - 1);
      r        = '0;
      case (op)
         OP_HOLD: sp_mirror[j] = meas;
         OP_COMMAND: begin
            tgt_mirror[j]  = tol;
            down_mirror[j] = (meas > tol);
            if (elem_count < ELEMENT_COUNT_MAX) elem_count++;
            if (last) begin
               if (elem_count != n) begin
                  r.len_err = 1'b1;
                  motion_on = 1'b0;
               end else begin
                  done_mask = '0;
                  motion_on = 1'b1;
               end
               elem_count = '0;
            end
         end
         OP_TICK: begin
            if (motion_on && j < n && !done_mask[j]) begin
               // Step from the measured position; wide math so the edges never wrap.
               nv   = down_mirror[j] ? longint'(meas) - longint'(step_reg)
                                     : longint'(meas) + longint'(step_reg);
               done = 1'b1;
               if (nv <= lo_mirror[j]) nv = lo_mirror[j];
               else if (nv >= hi_mirror[j]) nv = hi_mirror[j];
               else if ((!down_mirror[j] && nv >= tgt_mirror[j]) ||
                        (down_mirror[j] && nv <= tgt_mirror[j])) nv = tgt_mirror[j];
               else done = 1'b0;
               sp_mirror[j] = position_type'(nv);
               if (done) done_mask[j] = 1'b1;
            end
            if (last && motion_on && (done_mask & use_mask) == use_mask) begin
               motion_on  = 1'b0;
               r.all_done = 1'b1;
            end
         end
         default: begin
            lo_mirror[j] = tol;
            hi_mirror[j] = upp;
         end
      endcase
      r.joint    = j;
      r.setpoint = sp_mirror[j];
      r.reached  = done_mask[j];
      r.moving   = motion_on;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. Call at a rising edge; returns at the accepting edge
   // with valid still high, so back-to-back requests never drop valid.
   // ---------------------------------------------------------------------
   task automatic send_request(opcode_type op, logic [JOINT_INDEX_W-1:0] j,
         position_type meas, position_type tol, position_type upp, logic last);
      int               gap;
      joint_report_type due;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_opcode            <= op;
      req_joint_index       <= j;
      req_measured_position <= meas;
      req_target_or_lower   <= tol;
      req_upper_limit       <= upp;
      req_last_element      <= last;
      due = predict_joint_update(op, j, meas, tol, upp, last);
      joint_reports_due.insert(joint_reports_due.size(), due);
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_noise();
      send_request(opcode_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                   position_type'($urandom), position_type'($urandom),
                   position_type'($urandom), $urandom_range(0, 1));
   endtask

   // Drop valid and hold off until every owed report is back and the pipe is empty.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (joint_reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // CSR writes only land on an idle block.
   task automatic write_csr(csr_reg_type idx, logic [CSR_DATA_W-1:0] data);
      wait_for_drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_JOINT_COUNT) jc_reg = data[JOINT_COUNT_W-1:0];
      else step_reg = data[STEP_SIZE_W-1:0];
      csr_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, an optional long hold-off, and the check.
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      joint_report_type got;
      joint_report_type want;
      int               stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            // Hold off long enough for the block to fill and push back on requests.
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.joint    = rsp_out_joint;
         got.setpoint = rsp_setpoint;
         got.reached  = rsp_joint_reached;
         got.all_done = rsp_all_reached;
         got.moving   = rsp_moving;
         got.len_err  = rsp_length_error;
         if (got.len_err === 1'b1) length_errors_seen++;
         if (got.all_done === 1'b1) completions_seen++;
         if (joint_reports_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] response with no request outstanding: joint=%0d sp=%0d",
                        $time, got.joint, $signed(got.setpoint));
         end else begin
            want = joint_reports_due.pop_front();
            reports_checked++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] mismatch exp j=%0d sp=%0d rch=%b all=%b mov=%b lerr=%b%s",
                           $time, want.joint, $signed(want.setpoint), want.reached,
                           want.all_done, want.moving, want.len_err,
                           $sformatf(" | got j=%0d sp=%0d rch=%b all=%b mov=%b lerr=%b",
                                     got.joint, $signed(got.setpoint), got.reached,
                                     got.all_done, got.moving, got.len_err));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Full-scale step at both ends of the position range: clamp to the range limits.
   task automatic test_clamp_at_extremes();
      write_csr(CSR_JOINT_COUNT, 2);
      write_csr(CSR_STEP_SIZE, '1);
      send_request(OP_LIMITS, 0, 0, POS_MIN, POS_MAX, 1'b0);
      send_request(OP_LIMITS, 1, 0, POS_MIN, POS_MAX, 1'b1);
      send_request(OP_COMMAND, 0, POS_MAX - 1, POS_MAX - 1, 0, 1'b0);
      send_request(OP_COMMAND, 1, POS_MIN + 1, POS_MIN, 0, 1'b1);
      send_request(OP_TICK, 0, POS_MAX, 0, 0, 1'b0);
      send_request(OP_TICK, 1, POS_MIN, 0, 0, 1'b1);
   endtask

   // Lower limit wins over upper in an inverted window; snap to target; ignored ticks.
   task automatic test_limit_order_and_snap();
      write_csr(CSR_STEP_SIZE, 1);
      send_request(OP_LIMITS, 0, 0, 100, -100, 1'b0);
      send_request(OP_LIMITS, 1, 0, -1000, 1000, 1'b0);
      send_request(OP_COMMAND, 0, 0, 50, 0, 1'b0);
      send_request(OP_COMMAND, 1, 0, -3, 0, 1'b1);
      send_request(OP_TICK, 0, 0, 0, 0, 1'b0);
      send_request(OP_TICK, 1, 0, 0, 0, 1'b1);
      // Joint 0 is already done, joint 7 is outside the joint count.
      send_request(OP_TICK, 0, 0, 0, 0, 1'b0);
      send_request(OP_TICK, 7, 0, 0, 0, 1'b0);
      // Hold and limit loads leave motion alone.
      send_request(OP_HOLD, 1, 5, 0, 0, 1'b0);
      send_request(OP_LIMITS, 9, 0, -5, 5, 1'b1);
      send_request(OP_TICK, 1, -2, 0, 0, 1'b1);
      // Motion has stopped: this tick must change nothing.
      send_request(OP_TICK, 1, 40, 0, 0, 1'b1);
   endtask

   // Retarget a joint mid-motion, restart on a matching count, abort on a short one.
   task automatic test_command_while_moving();
      send_request(OP_COMMAND, 0, 200, 300, 0, 1'b0);
      send_request(OP_COMMAND, 1, 0, 900, 0, 1'b1);
      // Above the inverted window: upper limit is taken before the target check.
      send_request(OP_TICK, 0, 200, 0, 0, 1'b0);
      send_request(OP_COMMAND, 1, 2000, 1000, 0, 1'b0);
      send_request(OP_TICK, 1, 2000, 0, 0, 1'b1);
      send_request(OP_COMMAND, 0, 0, 10, 0, 1'b1);
      send_request(OP_TICK, 1, 0, 0, 0, 1'b0);
      send_request(OP_COMMAND, 1, 0, 0, 0, 1'b1);
   endtask

   // Too many command elements, and hold at both position extremes.
   task automatic test_length_error_and_holds();
      send_request(OP_COMMAND, 0, 0, 0, 0, 1'b0);
      send_request(OP_COMMAND, 1, 0, 0, 0, 1'b0);
      send_request(OP_COMMAND, 2, 0, 0, 0, 1'b1);
      send_request(OP_HOLD, 15, POS_MIN, POS_MAX, POS_MIN, 1'b1);
      send_request(OP_HOLD, 14, POS_MAX, POS_MIN, POS_MAX, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Random traffic
   // ---------------------------------------------------------------------

   // Well-formed move: hold each joint at a start, command nearby targets, tick until done.
   task automatic run_move_sequence();
      int           n;
      int           rounds;
      longint       reach;
      longint       span;
      position_type start_pos [MJPR_MAX_JOINTS];
      position_type goal;
      n    = used_joints();
      span = longint'(step_reg) * 16;
      for (int j = 0; j < n; j++) begin
         start_pos[j] = random_position();
         send_request(OP_HOLD, j, start_pos[j], random_position(), random_position(),
                      $urandom_range(0, 1));
         // Now and then a fresh window around the start, sometimes tight enough to clamp.
         if ($urandom_range(0, 2) == 0)
            send_request(OP_LIMITS, j, random_position(),
                         clip_pos(longint'(start_pos[j]) - longint'($urandom_range(0, span))),
                         clip_pos(longint'(start_pos[j]) + longint'($urandom_range(0, span))),
                         $urandom_range(0, 1));
      end
      for (int j = 0; j < n; j++) begin
         reach = longint'(step_reg) * longint'($urandom_range(0, 12)) +
                 longint'($urandom_range(0, step_reg));
         goal  = clip_pos($urandom_range(0, 1) ? longint'(start_pos[j]) + reach
                                               : longint'(start_pos[j]) - reach);
         send_request(OP_COMMAND, j, start_pos[j], goal, random_position(), j == n - 1);
      end
      // Feed back the last setpoint as the measured position, with a little jitter.
      rounds = 0;
      while (motion_on && rounds < 30) begin
         for (int j = 0; j < n; j++)
            send_request(OP_TICK, j,
                         clip_pos(longint'(sp_mirror[j]) +
                                  longint'($urandom_range(0, step_reg / 2)) -
                                  longint'(step_reg / 4)),
                         random_position(), random_position(), j == n - 1);
         rounds++;
      end
   endtask

   // Command with the wrong element count, sometimes long enough to saturate the counter.
   task automatic run_broken_command();
      int count;
      if ($urandom_range(0, 2) == 0) count = $urandom_range(32, 40);
      else if (used_joints() > 1 && $urandom_range(0, 1) == 1) count = used_joints() - 1;
      else count = used_joints() + 1;
      for (int k = 0; k < count; k++)
         send_request(OP_COMMAND, $urandom_range(0, 15), random_position(),
                      random_position(), random_position(), k == count - 1);
   endtask

   task automatic test_random_traffic();
      int                    jc_picks [8] = '{0, 31, 1, 16, 7, 3, 17, 2};
      int                    base;
      int                    phase_base;
      int                    phase;
      logic [CSR_DATA_W-1:0] step_pick;
      // Load limits and targets on every joint before any tick can read them.
      for (int j = 0; j < MJPR_MAX_JOINTS; j++)
         send_request(OP_LIMITS, j, random_position(),
                      clip_pos(-longint'($urandom_range(1 << 20, 1 << 23))),
                      clip_pos(longint'($urandom_range(1 << 20, 1 << 23))), 1'b0);
      for (int j = 0; j < MJPR_MAX_JOINTS; j++)
         send_request(OP_COMMAND, j, random_position(), random_position(), 0,
                      j == MJPR_MAX_JOINTS - 1);
      base  = items_sent;
      phase = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         case (phase % 5)
            0:       step_pick = 1;
            1:       step_pick = '1;
            2:       step_pick = STEP_SIZE_RESET;
            3:       step_pick = $urandom_range(1, (1 << STEP_SIZE_W) - 1);
            default: step_pick = $urandom_range(1, 2000);
         endcase
         write_csr(CSR_JOINT_COUNT, (phase < 8) ? jc_picks[phase] : $urandom_range(0, 31));
         write_csr(CSR_STEP_SIZE, step_pick);
         // Rotate idle patterns, including a phase with no idling at all.
         req_gap_max   = (phase % 4 == 1 || phase % 4 == 3) ? 16 : 0;
         rsp_stall_max = (phase % 4 >= 2) ? 16 : 0;
         phase_base    = items_sent;
         while (items_sent - phase_base < 150) begin
            case ($urandom_range(0, 9))
               0:       repeat ($urandom_range(3, 10)) send_noise();
               1:       run_broken_command();
               default: run_move_sequence();
            endcase
         end
         phase++;
      end
   endtask

   // Long receiver hold-off while requests keep coming, then a drain and noise with random gaps and stalls.
   task automatic test_backpressure();
      wait_for_drain();
      req_gap_max     = 0;
      rsp_stall_max   = 0;
      rsp_hold_cycles = 120;
      repeat (40) send_noise();
      wait_for_drain();
      req_gap_max   = 16;
      rsp_stall_max = 16;
      repeat (30) send_noise();
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_clamp_at_extremes();
      test_limit_order_and_snap();
      test_command_while_moving();
      test_length_error_and_holds();
      test_random_traffic();
      test_backpressure();
      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("Ramp run: %0d requests sent, %0d responses checked, %0d CSR writes.",
               items_sent, reports_checked, csr_writes);
      $display("Joint counts 0..31, steps 1..max, stalls and hold-off: %0d length errors, %s",
               length_errors_seen, $sformatf("%0d completions.", completions_seen));
      if (mismatch_count == 0 && joint_reports_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Generous bound well above the slowest legal run.
   initial begin : watchdog
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mjpr_pkg.sv
hdl/mjpr_joint_step.sv
hdl/mjpr_state.sv
hdl/multi_joint_position_ramp.sv
hdl/mjpr_checker.sv
tb/tb_multi_joint_position_ramp.sv
